FILE: sv/bba_pkg.sv
// Shared types, constants and helpers for the bitmap block allocator.
// No dependencies; imported by bba_ram and bitmap_block_allocator.
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 127;
    localparam int WORD_W         = 32;
    localparam int WORD_SHIFT     = 5;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_CLAIM = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // lowest clear bit of a word: {found, index}
    function automatic logic [WORD_SHIFT:0] find_first_zero(input logic [WORD_W-1:0] w);
        logic                  found;
        logic [WORD_SHIFT-1:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                found = 1'b1;
                idx   = WORD_SHIFT'(i);
            end
        end
        return {found, idx};
    endfunction

endpackage

FILE: sv/bitmap_block_allocator.sv
// Bitmap first-fit block allocator, top level.
// Depends on bba_pkg and bba_ram.
//
// Usage
//   Slave channel (s_axis_*): one request per transaction; tdata carries op in
//   bits [1:0] (allocate, claim, free) and the block number in bits [9:2].
//   Master channel (m_axis_*): exactly one result per request; tdata carries
//   block_out [7:0], status [10:8] and the free count after the request [18:11].
//   The used map lives in a RAM of 32-bit words, one bit per block, next to a
//   per-word written flag so an unwritten word reads as all-free.
// Operation
//   Claim, free, out-of-range and full requests are accepted in S_IDLE and
//   completed in S_EXEC, which writes the map word back when it changes. An
//   allocation scans the map one word per cycle through the RAM read port
//   while the output register has room, and stops at the first word holding
//   a free block. One request is in flight at a time.
// Reset
//   Synchronous, active low. The map reads as cleared straight away (written
//   flags drop), the free count returns to NUM_BLOCKS; no clearing pass.
// Back-pressure
//   The result sits in an output register. A new request is taken while it
//   waits; that request holds at its first read-modify-write cycle until the
//   register drains, then runs on as above.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op[1:0], block[9:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // block_out[7:0], status[10:8], free_count[18:11]
);

    localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW    = addr_w(WORDS);

    // request registers
    t_state         r_state, n_state;
    logic [1:0]     r_op;
    logic [7:0]     r_block;
    logic [AW-1:0]  r_addr, n_addr;
    logic [7:0]     r_free_count, n_free_count;
    logic [WORDS-1:0] r_written, n_written;
    logic           r_rd_valid;

    // result register
    logic           r_m_valid, n_m_valid;
    logic [7:0]     r_m_block, n_m_block;
    t_status        r_m_status, n_m_status;
    logic [7:0]     r_m_free, n_m_free;

    // RAM side
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic              in_acc, out_room, done;
    logic [WORD_W-1:0] word, scan_word, bit_mask;
    logic [WORD_SHIFT:0] ffz;
    logic              in_range, cur_bit;
    logic [1:0]        in_op;
    logic [7:0]        in_block;

    assign in_op    = s_axis_tdata[1:0];
    assign in_block = s_axis_tdata[9:2];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_room      = !r_m_valid || m_axis_tready;

    // unwritten words read as all-free
    assign word     = r_rd_valid ? ram_rdata : '0;
    assign in_range = (r_block < 8'(NUM_BLOCKS));
    assign bit_mask = WORD_W'(1) << r_block[WORD_SHIFT-1:0];
    assign cur_bit  = word[r_block[WORD_SHIFT-1:0]];

    // bits beyond the last block count as used during the scan
    always_comb begin
        scan_word = word;
        for (int i = 0; i < WORD_W; i++) begin
            if ((int'(r_addr) * WORD_W + i) >= NUM_BLOCKS) begin
                scan_word[i] = 1'b1;
            end
        end
    end

    assign ffz = find_first_zero(scan_word);

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_free_count = r_free_count;
        n_written    = r_written;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_block    = r_m_block;
        n_m_status   = r_m_status;
        n_m_free     = r_m_free;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_addr;
        ram_wdata    = word;
        done         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    ram_re    = 1'b1;
                    ram_raddr = (in_op == OP_ALLOC) ? '0 : AW'(in_block >> WORD_SHIFT);
                    n_addr    = ram_raddr;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_room) begin
                    n_m_block  = r_block;
                    n_m_status = ST_RANGE;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_free_count == '0) begin
                                n_m_block  = '0;
                                n_m_status = ST_FULL;
                                done       = 1'b1;
                            end else if (ffz[WORD_SHIFT]) begin
                                ram_wdata    = word | (WORD_W'(1) << ffz[WORD_SHIFT-1:0]);
                                ram_we       = 1'b1;
                                n_free_count = r_free_count - 8'd1;
                                n_m_block    = 8'({r_addr, ffz[WORD_SHIFT-1:0]});
                                n_m_status   = ST_OK;
                                done         = 1'b1;
                            end else begin
                                // word full, move on to the next one
                                n_addr    = r_addr + AW'(1);
                                ram_re    = 1'b1;
                                ram_raddr = n_addr;
                            end
                        end
                        OP_CLAIM: begin
                            done = 1'b1;
                            if (in_range) begin
                                if (cur_bit) begin
                                    n_m_status = ST_ALREADY;
                                end else begin
                                    ram_wdata    = word | bit_mask;
                                    ram_we       = 1'b1;
                                    n_free_count = r_free_count - 8'd1;
                                    n_m_status   = ST_OK;
                                end
                            end
                        end
                        OP_FREE: begin
                            done = 1'b1;
                            if (in_range) begin
                                if (!cur_bit) begin
                                    n_m_status = ST_NOT_ALLOC;
                                end else begin
                                    ram_wdata    = word & ~bit_mask;
                                    ram_we       = 1'b1;
                                    n_free_count = r_free_count + 8'd1;
                                    n_m_status   = ST_OK;
                                end
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                    if (ram_we) begin
                        n_written[r_addr] = 1'b1;
                    end
                    if (done) begin
                        n_m_valid = 1'b1;
                        n_m_free  = n_free_count;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= 8'(NUM_BLOCKS);
            r_written    <= '0;
            r_m_valid    <= 1'b0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_written    <= n_written;
            r_m_valid    <= n_m_valid;
            if (ram_re) begin
                r_rd_valid <= (int'(ram_raddr) < WORDS) ? r_written[ram_raddr] : 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= in_op;
            r_block <= in_block;
        end
        r_addr     <= n_addr;
        r_m_block  <= n_m_block;
        r_m_status <= n_m_status;
        r_m_free   <= n_m_free;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_free, r_m_status, r_m_block};

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= 8'(NUM_BLOCKS))
        else $error("free count above pool size");

    // count moves only when a request completes
    a_free_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !done |=> $stable(r_free_count))
        else $error("free count changed without a completed request");

    // a successful result always names a block inside the pool
    a_ok_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_m_status == ST_OK)) |-> (r_m_block < 8'(NUM_BLOCKS)))
        else $error("ok result outside pool");

    // an allocation scan never runs past the last map word
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == OP_ALLOC && r_free_count != '0)
            |-> (int'(r_addr) < WORDS))
        else $error("allocation scan past end of map");

    // full status only when the count is zero
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_m_status == ST_FULL)) |-> (r_m_free == '0))
        else $error("full reported with free blocks left");

endmodule

FILE: sv/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on bba_pkg for the address width helper.
module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH  = WORD_W,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = addr_w(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
